FILE: sv/stscan_pkg.sv
// Shared types, token kind codes and character classes for the source token scanner.
// No dependencies; imported by source_token_scanner_unit.
package stscan_pkg;

    localparam int MAX_COMMENT_DEPTH = 15;
    localparam int OFFSET_BITS       = 24;
    localparam int LINE_BITS         = 16;
    localparam int LEN_BITS          = 16;
    localparam int KIND_BITS         = 6;
    localparam int DEPTH_BITS        = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam int PREFIX_BYTES      = 6;
    localparam int KW_COUNT          = 13;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_AW           = $clog2(FIFO_DEPTH);

    localparam logic [LINE_BITS-1:0]  LINE_TOP = {LINE_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   LEN_TOP  = {LEN_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = DEPTH_BITS'(MAX_COMMENT_DEPTH);

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_FRAC,
        M_HELD,
        M_LINE,
        M_BLOCK,
        M_BSTAR,
        M_BSLASH
    } lex_mode_t;

    // token kinds
    localparam logic [KIND_BITS-1:0] TK_EOF     = 6'd0;
    localparam logic [KIND_BITS-1:0] TK_ERROR   = 6'd1;
    localparam logic [KIND_BITS-1:0] TK_IDENT   = 6'd2;
    localparam logic [KIND_BITS-1:0] TK_INT     = 6'd3;
    localparam logic [KIND_BITS-1:0] TK_DOUBLE  = 6'd4;
    localparam logic [KIND_BITS-1:0] TK_FLOAT   = 6'd5;
    localparam logic [KIND_BITS-1:0] TK_LPAREN  = 6'd6;
    localparam logic [KIND_BITS-1:0] TK_RPAREN  = 6'd7;
    localparam logic [KIND_BITS-1:0] TK_LBRACE  = 6'd8;
    localparam logic [KIND_BITS-1:0] TK_RBRACE  = 6'd9;
    localparam logic [KIND_BITS-1:0] TK_LBRACK  = 6'd10;
    localparam logic [KIND_BITS-1:0] TK_RBRACK  = 6'd11;
    localparam logic [KIND_BITS-1:0] TK_SEMI    = 6'd12;
    localparam logic [KIND_BITS-1:0] TK_COMMA   = 6'd13;
    localparam logic [KIND_BITS-1:0] TK_DOT     = 6'd14;
    localparam logic [KIND_BITS-1:0] TK_MINUS   = 6'd15;
    localparam logic [KIND_BITS-1:0] TK_PLUS    = 6'd16;
    localparam logic [KIND_BITS-1:0] TK_SLASH   = 6'd17;
    localparam logic [KIND_BITS-1:0] TK_STAR    = 6'd18;
    localparam logic [KIND_BITS-1:0] TK_ASSIGN  = 6'd19;
    localparam logic [KIND_BITS-1:0] TK_NEWLINE = 6'd21;
    localparam logic [KIND_BITS-1:0] TK_NOT     = 6'd22;
    localparam logic [KIND_BITS-1:0] TK_LT      = 6'd24;
    localparam logic [KIND_BITS-1:0] TK_GT      = 6'd26;
    localparam logic [KIND_BITS-1:0] TK_KW_BASE = 6'd28;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // keyword text, first byte lowest
    localparam logic [8*PREFIX_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
        48'h000000646E61,  // and
        48'h000000796E61,  // any
        48'h00006F747561,  // auto
        48'h000000666564,  // def
        48'h000065736C65,  // else
        48'h0065736C6166,  // false
        48'h000000726F66,  // for
        48'h000000006669,  // if
        48'h00006C6C756E,  // null
        48'h00000000726F,  // or
        48'h6E7275746572,  // return
        48'h000065757274,  // true
        48'h00656C696877   // while
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd2, 3'd6, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [LINE_BITS-1:0]   line_number;
        logic [LEN_BITS-1:0]    token_length;
        logic [OFFSET_BITS-1:0] token_start;
        logic [KIND_BITS-1:0]   token_kind;
    } token_t;

    typedef struct packed {
        logic   last;
        token_t tok;
    } out_entry_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic is_held_op(input logic [7:0] c);
        return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT || c == CH_SLASH;
    endfunction

    function automatic logic [KIND_BITS-1:0] kw_kind(input logic [LEN_BITS-1:0] len,
                                                     input logic [8*PREFIX_BYTES-1:0] text);
        logic [KIND_BITS-1:0] kind;
        kind = TK_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == LEN_BITS'(KW_LEN[i]) && text == KW_TEXT[i]) begin
                kind = TK_KW_BASE + KIND_BITS'(i);
            end
        end
        return kind;
    endfunction

    function automatic logic [KIND_BITS-1:0] held_kind(input logic [7:0] op);
        logic [KIND_BITS-1:0] kind;
        case (op)
            CH_EQ:   kind = TK_ASSIGN;
            CH_BANG: kind = TK_NOT;
            CH_LT:   kind = TK_LT;
            CH_GT:   kind = TK_GT;
            default: kind = TK_SLASH;
        endcase
        return kind;
    endfunction

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] kind;
        case (c)
            CH_LPAREN: kind = TK_LPAREN;
            CH_RPAREN: kind = TK_RPAREN;
            CH_LBRACE: kind = TK_LBRACE;
            CH_RBRACE: kind = TK_RBRACE;
            CH_LBRACK: kind = TK_LBRACK;
            CH_RBRACK: kind = TK_RBRACK;
            CH_SEMI:   kind = TK_SEMI;
            CH_COMMA:  kind = TK_COMMA;
            CH_DOT:    kind = TK_DOT;
            CH_MINUS:  kind = TK_MINUS;
            CH_PLUS:   kind = TK_PLUS;
            CH_STAR:   kind = TK_STAR;
            default:   kind = TK_ERROR;
        endcase
        return kind;
    endfunction

endpackage

FILE: sv/source_token_scanner_unit.sv
// Source token scanner: one source byte in, up to two tokens out, through a 4-entry queue.
// Depends on stscan_pkg (kind codes, character classes, keyword table, token struct).
//
//  channel | dir | tdata (low bit first)                                    | tlast
//  --------+-----+----------------------------------------------------------+---------------
//  s_      | in  | ch[7:0]                                                  | -
//  m_      | out | token_kind[5:0] start[29:6] length[45:30] line[61:46] 0  | last_of_run
//
// One byte is taken every cycle while s_tready is high; its tokens land in the queue in the same edge.
// The lexer state and the queue pointers are the only loop; throughput is one byte per
// cycle while the queue has two free slots, so bytes that yield two tokens fill the queue
// faster than the consumer can drain it, and can stall the input.
// Reset clears the lexer state and empties the queue; a byte 0 returns the lexer to it.
module source_token_scanner_unit
    import stscan_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // kind[5:0], start[29:6], length[45:30], line[61:46]
    output logic        m_tlast
);

    lex_mode_t                 mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]    pstart_reg, pstart_next;
    logic [OFFSET_BITS-1:0]    pos_reg, pos_next;
    logic [LEN_BITS-1:0]       plen_reg, plen_next;
    logic [LINE_BITS-1:0]      line_reg, line_next;
    logic [8*PREFIX_BYTES-1:0] prefix_reg, prefix_next;
    logic [DEPTH_BITS-1:0]     depth_reg, depth_next;
    logic [7:0]                held_reg, held_next;

    logic [7:0]            ch;
    logic                  in_acc;
    logic [LEN_BITS-1:0]   plen_inc;
    logic [LINE_BITS-1:0]  line_bump;
    logic [DEPTH_BITS-1:0] depth_dec;

    logic                  p_v, f_v, do_fresh;
    logic [KIND_BITS-1:0]  p_kind, f_kind;
    logic [LEN_BITS-1:0]   p_len, f_len;
    logic [LINE_BITS-1:0]  f_line;
    token_t                p_tok, f_tok;
    out_entry_t            slot0, slot1;
    logic [1:0]            push_n;

    out_entry_t            fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_reg, rd_reg;
    logic [FIFO_AW:0]      cnt_reg;
    logic                  pop;

    assign ch        = s_tdata;
    assign in_acc    = s_tvalid && s_tready;
    assign plen_inc  = (plen_reg == LEN_TOP) ? plen_reg : plen_reg + 1'b1;
    assign line_bump = (line_reg == LINE_TOP) ? line_reg : line_reg + 1'b1;
    assign depth_dec = (depth_reg == '0) ? depth_reg : depth_reg - 1'b1;

    // token emission
    always_comb
    begin
        p_v      = 1'b0;
        p_kind   = TK_IDENT;
        p_len    = plen_reg;
        do_fresh = 1'b0;
        if (ch == CH_NUL)
        begin
            unique case (mode_reg) inside
                M_IDENT:
                begin
                    p_v    = 1'b1;
                    p_kind = kw_kind(plen_reg, prefix_reg);
                end
                M_INT:
                begin
                    p_v    = 1'b1;
                    p_kind = TK_INT;
                end
                M_FRAC:
                begin
                    p_v    = 1'b1;
                    p_kind = TK_DOUBLE;
                end
                M_HELD:
                begin
                    p_v    = 1'b1;
                    p_kind = held_kind(held_reg);
                    p_len  = LEN_BITS'(1);
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (mode_reg) inside
                M_IDLE:
                    do_fresh = 1'b1;
                M_IDENT:
                    if (!is_word(ch))
                    begin
                        p_v = 1'b1;
                        if (ch == CH_BANG)
                        begin
                            p_kind = TK_IDENT;
                            p_len  = plen_inc;
                        end
                        else
                        begin
                            p_kind   = kw_kind(plen_reg, prefix_reg);
                            do_fresh = 1'b1;
                        end
                    end
                M_INT:
                    if (!is_digit(ch) && ch != CH_DOT)
                    begin
                        p_v      = 1'b1;
                        p_kind   = TK_INT;
                        do_fresh = 1'b1;
                    end
                M_FRAC:
                    if (!is_digit(ch))
                    begin
                        p_v = 1'b1;
                        if (ch == CH_LOW_F)
                        begin
                            p_kind = TK_FLOAT;
                            p_len  = plen_inc;
                        end
                        else
                        begin
                            p_kind   = TK_DOUBLE;
                            do_fresh = 1'b1;
                        end
                    end
                M_HELD:
                    if (held_reg == CH_SLASH)
                    begin
                        if (ch != CH_SLASH && ch != CH_STAR)
                        begin
                            p_v      = 1'b1;
                            p_kind   = TK_SLASH;
                            p_len    = LEN_BITS'(1);
                            do_fresh = 1'b1;
                        end
                    end
                    else if (ch == CH_EQ)
                    begin
                        p_v    = 1'b1;
                        p_kind = held_kind(held_reg) + 1'b1;
                        p_len  = LEN_BITS'(2);
                    end
                    else
                    begin
                        p_v      = 1'b1;
                        p_kind   = held_kind(held_reg);
                        p_len    = LEN_BITS'(1);
                        do_fresh = 1'b1;
                    end
                M_LINE:
                    do_fresh = (ch == CH_LF);
                default: ;
            endcase
        end

        f_v    = 1'b0;
        f_kind = TK_ERROR;
        f_len  = LEN_BITS'(1);
        f_line = (ch == CH_LF) ? line_bump : line_reg;
        if (ch == CH_NUL)
        begin
            f_v    = 1'b1;
            f_kind = TK_EOF;
            f_len  = '0;
        end
        else if (do_fresh)
        begin
            if (ch == CH_LF)
            begin
                f_v    = 1'b1;
                f_kind = TK_NEWLINE;
            end
            else if (!(ch == CH_SPACE || ch == CH_CR || ch == CH_TAB || is_word(ch)
                       || is_held_op(ch)))
            begin
                f_v    = 1'b1;
                f_kind = single_kind(ch);
            end
        end
    end

    // lexer next state
    always_comb
    begin
        mode_next   = mode_reg;
        pstart_next = pstart_reg;
        pos_next    = pos_reg + 1'b1;
        plen_next   = plen_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        depth_next  = depth_reg;
        held_next   = held_reg;
        if (ch == CH_NUL)
        begin
            mode_next   = M_IDLE;
            pstart_next = '0;
            pos_next    = '0;
            plen_next   = '0;
            line_next   = LINE_BITS'(1);
            prefix_next = '0;
            depth_next  = '0;
            held_next   = '0;
        end
        else
        begin
            unique case (mode_reg) inside
                M_IDENT:
                    if (is_word(ch) || ch == CH_BANG)
                    begin
                        if (plen_reg < LEN_BITS'(PREFIX_BYTES))
                        begin
                            prefix_next[{plen_reg[2:0], 3'b000} +: 8] = ch;
                        end
                        plen_next = plen_inc;
                        if (ch == CH_BANG)
                        begin
                            mode_next = M_IDLE;
                        end
                    end
                M_INT:
                    if (is_digit(ch) || ch == CH_DOT)
                    begin
                        plen_next = plen_inc;
                        if (ch == CH_DOT)
                        begin
                            mode_next = M_FRAC;
                        end
                    end
                M_FRAC:
                    if (is_digit(ch) || ch == CH_LOW_F)
                    begin
                        plen_next = plen_inc;
                        if (ch == CH_LOW_F)
                        begin
                            mode_next = M_IDLE;
                        end
                    end
                M_HELD:
                    if (held_reg == CH_SLASH)
                    begin
                        if (ch == CH_SLASH)
                        begin
                            mode_next = M_LINE;
                        end
                        else if (ch == CH_STAR)
                        begin
                            mode_next  = M_BLOCK;
                            depth_next = DEPTH_BITS'(1);
                        end
                    end
                    else if (ch == CH_EQ)
                    begin
                        mode_next = M_IDLE;
                    end
                M_BLOCK, M_BSTAR, M_BSLASH:
                    if (ch == CH_LF)
                    begin
                        line_next = line_bump;
                        mode_next = M_BLOCK;
                    end
                    else if (mode_reg == M_BSTAR && ch == CH_SLASH)
                    begin
                        depth_next = depth_dec;
                        mode_next  = (depth_dec == '0) ? M_IDLE : M_BLOCK;
                    end
                    else if (mode_reg == M_BSLASH && ch == CH_STAR)
                    begin
                        if (depth_reg < DEPTH_TOP)
                        begin
                            depth_next = depth_reg + 1'b1;
                        end
                        mode_next = M_BLOCK;
                    end
                    else if (ch == CH_STAR)
                    begin
                        mode_next = M_BSTAR;
                    end
                    else if (ch == CH_SLASH)
                    begin
                        mode_next = M_BSLASH;
                    end
                    else
                    begin
                        mode_next = M_BLOCK;
                    end
                default: ;
            endcase

            if (do_fresh)
            begin
                mode_next = M_IDLE;
                if (is_alpha(ch) || ch == CH_UNDER || is_digit(ch) || is_held_op(ch))
                begin
                    mode_next   = is_digit(ch) ? M_INT : (is_held_op(ch) ? M_HELD : M_IDENT);
                    pstart_next = pos_reg;
                    plen_next   = LEN_BITS'(1);
                    prefix_next = {{(8*PREFIX_BYTES-8){1'b0}}, ch};
                    if (is_held_op(ch))
                    begin
                        held_next = ch;
                    end
                end
                else if (ch == CH_LF)
                begin
                    line_next = line_bump;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pstart_reg <= '0;
            pos_reg    <= '0;
            plen_reg   <= '0;
            line_reg   <= LINE_BITS'(1);
            prefix_reg <= '0;
            depth_reg  <= '0;
            held_reg   <= '0;
        end
        else if (in_acc)
        begin
            mode_reg   <= mode_next;
            pstart_reg <= pstart_next;
            pos_reg    <= pos_next;
            plen_reg   <= plen_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            depth_reg  <= depth_next;
            held_reg   <= held_next;
        end
    end

    // result queue
    always_comb
    begin
        p_tok = '{line_number: line_reg, token_length: p_len,
                  token_start: pstart_reg, token_kind: p_kind};
        f_tok = '{line_number: f_line, token_length: f_len,
                  token_start: pos_reg, token_kind: f_kind};
        slot0 = '{last: !(p_v && f_v), tok: (p_v ? p_tok : f_tok)};
        slot1 = '{last: 1'b1, tok: f_tok};
        push_n = in_acc ? ({1'b0, p_v} + {1'b0, f_v}) : 2'd0;
    end

    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {2'b00, fifo_reg[rd_reg].tok};
    assign m_tlast  = fifo_reg[rd_reg].last;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_reg + 1'b1] <= slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + FIFO_AW'(push_n);
            rd_reg  <= rd_reg + FIFO_AW'(pop);
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tdata == CH_NUL) |=> (mode_reg == M_IDLE && pos_reg == '0
                                          && line_reg == LINE_BITS'(1)))
        else $error("end of input did not return lexer to idle");

    a_block_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_BLOCK || mode_reg == M_BSTAR || mode_reg == M_BSLASH)
        == (depth_reg != '0))
        else $error("comment depth out of step with comment mode");

    a_two_token_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (!slot0.last && slot1.last))
        else $error("two-token request with wrong last marking");

endmodule

FILE: test/source_token_scanner_unit_test.sv
// Testbench for source_token_scanner_unit: streams source bytes and checks every token
// against a scoreboard that tracks the lexer state itself. Depends on stscan_pkg and source_token_scanner_unit.
module source_token_scanner_unit_test
    import stscan_pkg::*;
();

    localparam logic [47:0] KEYWORDS [KW_COUNT] = '{
        "and", "any", "auto", "def", "else", "false", "for",
        "if", "null", "or", "return", "true", "while"
    };

    class token_scoreboard;
        lex_mode_t              mode;
        logic [OFFSET_BITS-1:0] lexeme_start;
        logic [OFFSET_BITS-1:0] position;
        int unsigned            lexeme_len;
        logic [LINE_BITS-1:0]   line;
        logic [47:0]            prefix;
        int unsigned            depth;
        logic [7:0]             held;
        int unsigned            emitted;
        out_entry_t             expected_tokens[$];
        int unsigned            mismatches;
        int unsigned            checked;
        logic [63:0]            kinds_seen;

        function new();
            mismatches = 0;
            checked = 0;
            kinds_seen = '0;
            restart();
        endfunction

        function void restart();
            mode = M_IDLE;
            lexeme_start = '0;
            position = '0;
            lexeme_len = 0;
            line = LINE_BITS'(1);
            prefix = '0;
            depth = 0;
            held = '0;
        endfunction

        function logic letter_byte(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function logic numeral_byte(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void push_token(logic [KIND_BITS-1:0] kind, logic [OFFSET_BITS-1:0] at,
                                 int unsigned len);
            out_entry_t e;
            e.last = 1'b0;
            e.tok.token_kind = kind;
            e.tok.token_start = at;
            e.tok.token_length = (len > 65535) ? LEN_TOP : LEN_BITS'(len);
            e.tok.line_number = line;
            expected_tokens.push_back(e);
            emitted++;
        endfunction

        function void mark_last();
            out_entry_t e;
            e = expected_tokens.pop_back();
            e.last = 1'b1;
            expected_tokens.push_back(e);
        endfunction

        function void extend(logic [7:0] c);
            if (lexeme_len < 6)
                prefix = {prefix[39:0], c};
            if (lexeme_len < 65535)
                lexeme_len++;
        endfunction

        function void open_lexeme(lex_mode_t m, logic [7:0] c, logic [OFFSET_BITS-1:0] at);
            mode = m;
            lexeme_start = at;
            lexeme_len = 0;
            prefix = '0;
            extend(c);
        endfunction

        function logic [KIND_BITS-1:0] word_kind();
            for (int i = 0; i < KW_COUNT; i++)
            begin
                if (lexeme_len <= 6 && prefix == KEYWORDS[i])
                    return TK_KW_BASE + KIND_BITS'(i);
            end
            return TK_IDENT;
        endfunction

        function logic [KIND_BITS-1:0] lone_kind(logic [7:0] op);
            case (op)
                CH_EQ:   return TK_ASSIGN;
                CH_BANG: return TK_NOT;
                CH_LT:   return TK_LT;
                CH_GT:   return TK_GT;
                default: return TK_SLASH;
            endcase
        endfunction

        function void next_line();
            if (line != LINE_TOP)
                line++;
        endfunction

        function void start_fresh(logic [7:0] c, logic [OFFSET_BITS-1:0] at);
            logic [KIND_BITS-1:0] k;
            mode = M_IDLE;
            if (c == CH_SPACE || c == CH_CR || c == CH_TAB)
                return;
            if (letter_byte(c) || c == CH_UNDER)
            begin
                open_lexeme(M_IDENT, c, at);
                return;
            end
            if (numeral_byte(c))
            begin
                open_lexeme(M_INT, c, at);
                return;
            end
            if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT || c == CH_SLASH)
            begin
                open_lexeme(M_HELD, c, at);
                held = c;
                return;
            end
            if (c == CH_LF)
            begin
                next_line();
                push_token(TK_NEWLINE, at, 1);
                return;
            end
            case (c)
                CH_LPAREN: k = TK_LPAREN;
                CH_RPAREN: k = TK_RPAREN;
                CH_LBRACE: k = TK_LBRACE;
                CH_RBRACE: k = TK_RBRACE;
                CH_LBRACK: k = TK_LBRACK;
                CH_RBRACK: k = TK_RBRACK;
                CH_SEMI:   k = TK_SEMI;
                CH_COMMA:  k = TK_COMMA;
                CH_DOT:    k = TK_DOT;
                CH_MINUS:  k = TK_MINUS;
                CH_PLUS:   k = TK_PLUS;
                CH_STAR:   k = TK_STAR;
                default:   k = TK_ERROR;
            endcase
            push_token(k, at, 1);
        endfunction

        function void take_byte(logic [7:0] c);
            logic [OFFSET_BITS-1:0] at;
            at = position;
            emitted = 0;
            if (c == CH_NUL)
            begin
                case (mode)
                    M_IDENT: push_token(word_kind(), lexeme_start, lexeme_len);
                    M_INT:   push_token(TK_INT, lexeme_start, lexeme_len);
                    M_FRAC:  push_token(TK_DOUBLE, lexeme_start, lexeme_len);
                    M_HELD:  push_token(lone_kind(held), lexeme_start, 1);
                    default: ;
                endcase
                push_token(TK_EOF, at, 0);
                mark_last();
                restart();
                return;
            end
            case (mode)
                M_IDENT:
                begin
                    if (letter_byte(c) || numeral_byte(c) || c == CH_UNDER)
                        extend(c);
                    else if (c == CH_BANG)
                    begin
                        extend(c);
                        push_token(TK_IDENT, lexeme_start, lexeme_len);
                        mode = M_IDLE;
                    end
                    else
                    begin
                        push_token(word_kind(), lexeme_start, lexeme_len);
                        start_fresh(c, at);
                    end
                end
                M_INT:
                begin
                    if (numeral_byte(c))
                        extend(c);
                    else if (c == CH_DOT)
                    begin
                        extend(c);
                        mode = M_FRAC;
                    end
                    else
                    begin
                        push_token(TK_INT, lexeme_start, lexeme_len);
                        start_fresh(c, at);
                    end
                end
                M_FRAC:
                begin
                    if (numeral_byte(c))
                        extend(c);
                    else if (c == CH_LOW_F)
                    begin
                        extend(c);
                        push_token(TK_FLOAT, lexeme_start, lexeme_len);
                        mode = M_IDLE;
                    end
                    else
                    begin
                        push_token(TK_DOUBLE, lexeme_start, lexeme_len);
                        start_fresh(c, at);
                    end
                end
                M_HELD:
                begin
                    if (held == CH_SLASH)
                    begin
                        if (c == CH_SLASH)
                            mode = M_LINE;
                        else if (c == CH_STAR)
                        begin
                            mode = M_BLOCK;
                            depth = 1;
                        end
                        else
                        begin
                            push_token(TK_SLASH, lexeme_start, 1);
                            start_fresh(c, at);
                        end
                    end
                    else if (c == CH_EQ)
                    begin
                        push_token(lone_kind(held) + 1'b1, lexeme_start, 2);
                        mode = M_IDLE;
                    end
                    else
                    begin
                        push_token(lone_kind(held), lexeme_start, 1);
                        start_fresh(c, at);
                    end
                end
                M_LINE:
                begin
                    if (c == CH_LF)
                        start_fresh(c, at);
                end
                M_BLOCK, M_BSTAR, M_BSLASH:
                begin
                    if (c == CH_LF)
                    begin
                        next_line();
                        mode = M_BLOCK;
                    end
                    else if (mode == M_BSTAR && c == CH_SLASH)
                    begin
                        if (depth > 0)
                            depth--;
                        mode = (depth == 0) ? M_IDLE : M_BLOCK;
                    end
                    else if (mode == M_BSLASH && c == CH_STAR)
                    begin
                        if (depth < MAX_COMMENT_DEPTH)
                            depth++;
                        mode = M_BLOCK;
                    end
                    else if (c == CH_STAR)
                        mode = M_BSTAR;
                    else if (c == CH_SLASH)
                        mode = M_BSLASH;
                    else
                        mode = M_BLOCK;
                end
                default: start_fresh(c, at);
            endcase
            position = at + 1'b1;
            if (emitted > 0)
                mark_last();
        endfunction

        function void check_token(logic [63:0] data, logic last);
            out_entry_t e;
            checked++;
            kinds_seen[data[5:0]] = 1'b1;
            if (expected_tokens.size() == 0)
            begin
                $error("token with nothing expected: kind %0d start %0d", data[5:0], data[29:6]);
                mismatches++;
                return;
            end
            e = expected_tokens.pop_front();
            if (data[5:0] != e.tok.token_kind)
            begin
                $error("token_kind: expected %0d, got %0d", e.tok.token_kind, data[5:0]);
                mismatches++;
            end
            if (data[29:6] != e.tok.token_start)
            begin
                $error("token_start: expected %0d, got %0d", e.tok.token_start, data[29:6]);
                mismatches++;
            end
            if (data[45:30] != e.tok.token_length)
            begin
                $error("token_length: expected %0d, got %0d", e.tok.token_length, data[45:30]);
                mismatches++;
            end
            if (data[61:46] != e.tok.line_number)
            begin
                $error("line_number: expected %0d, got %0d", e.tok.line_number, data[61:46]);
                mismatches++;
            end
            if (data[63:62] != 2'b00)
            begin
                $error("padding: expected 0, got %0d", data[63:62]);
                mismatches++;
            end
            if (last != e.last)
            begin
                $error("last_of_run: expected %0d, got %0d", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     bytes_sent = 0;
    token_scoreboard ledger;

    source_token_scanner_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_token(m_tdata, m_tlast);
    end

    initial
    begin
        #30000000;
        $display("Simulation FAILED");
        $finish;
    end

    // enter and leave at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ledger.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] word_char();
        int unsigned r;
        r = $urandom_range(62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r < 62)
            return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic send_lexeme();
        int unsigned r;
        int unsigned n;
        logic [47:0] kw;
        logic [7:0]  b;
        r = $urandom_range(99);
        if (r < 18)
        begin
            send_byte($urandom_range(3) == 0 ? CH_UNDER : 8'("a" + $urandom_range(25)));
            n = $urandom_range(7);
            repeat (n) send_byte(word_char());
            if ($urandom_range(3) == 0)
                send_byte(CH_BANG);
        end
        else if (r < 30)
        begin
            kw = KEYWORDS[$urandom_range(KW_COUNT - 1)];
            n = ($urandom_range(4) == 0) ? 1 : 0;
            for (int i = 5; i >= 0; i--)
            begin
                b = kw[8*i +: 8];
                if (b != 8'h00 && !(n == 1 && i == 0))
                    send_byte(b);
            end
            if ($urandom_range(4) == 0)
                send_byte($urandom_range(1) ? word_char() : CH_BANG);
        end
        else if (r < 42)
        begin
            repeat ($urandom_range(4, 1)) send_byte(8'("0" + $urandom_range(9)));
            if ($urandom_range(1))
            begin
                send_byte(CH_DOT);
                repeat ($urandom_range(3)) send_byte(8'("0" + $urandom_range(9)));
                if ($urandom_range(4) < 2)
                    send_byte(CH_LOW_F);
            end
        end
        else if (r < 58)
        begin
            if ($urandom_range(2) == 0)
            begin
                send_byte(pick("=!<>/"));
                send_byte(CH_EQ);
            end
            else
                send_byte(pick("(){}[];,.-+*=!<>/"));
        end
        else if (r < 66)
            send_byte(pick(" \t\015\n"));
        else if (r < 72)
        begin
            send_text("//");
            repeat ($urandom_range(6))
            begin
                b = 8'($urandom_range(255, 1));
                send_byte(b == CH_LF ? CH_SPACE : b);
            end
            send_byte(CH_LF);
        end
        else if (r < 80)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(18, 14) : $urandom_range(3, 1);
            repeat (n)
            begin
                send_text("/*");
                repeat ($urandom_range(3)) send_byte(pick("ab \n*x/"));
            end
            repeat (n)
            begin
                repeat ($urandom_range(2)) send_byte(pick("ab \n*x/"));
                send_text("*/");
            end
        end
        else if (r < 88)
            send_byte($urandom_range(1) ? 8'($urandom_range(255, 128))
                                         : pick("#$%&'\"?@\\^\140|~:\001\013\014\033\177"));
        else if (r < 96)
            send_byte(8'($urandom_range(255, 1)));
        else if (r < 99)
            send_byte(CH_NUL);
        else
            repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
        if ($urandom_range(1))
            send_byte(CH_SPACE);
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned dst_pct,
                             input int unsigned until_bytes);
        send_idle_pct = src_pct;
        recv_idle_pct = dst_pct;
        while (bytes_sent < until_bytes)
            send_lexeme();
    endtask

    initial
    begin
        int unsigned drain;
        int unsigned kind_count;
        ledger = new();
        send_idle_pct = 10;
        recv_idle_pct = 57;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("_a9!=1.5f<=x>=2.==y/=z!w//q\200\n/*/**/\n*/\t\015(){}[];,.-+*/!<>\377\001#and");
        send_byte(CH_NUL);
        send_text("5");
        send_byte(CH_NUL);
        send_text("1.");
        send_byte(CH_NUL);
        send_text("<");
        send_byte(CH_NUL);
        send_text("/*x");
        send_byte(CH_NUL);

        run_phase(10, 57, 500);
        run_phase(57, 10, 950);
        run_phase(0, 0, 1400);

        send_byte(CH_NUL);

        s_tvalid <= 1'b0;
        drain = 0;
        while (ledger.expected_tokens.size() != 0 && drain < 10000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (16) @(posedge clk);
        if (ledger.expected_tokens.size() != 0)
        begin
            $error("%0d expected tokens never arrived", ledger.expected_tokens.size());
            ledger.mismatches++;
        end

        kind_count = $countones(ledger.kinds_seen);
        $display("Scanned %0d source bytes under three stall patterns, with nested comments",
                 bytes_sent);
        $display("and end-of-input restarts; checked %0d tokens of %0d distinct kinds",
                 ledger.checked, kind_count);
        if (ledger.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
